// ----- design/mbr_pkg.sv -----
package mbr_pkg;

  // Field widths
  localparam int PIX_W  = 12;
  localparam int SIZE_W = 13;
  localparam int ITER_W = 11;
  localparam int OFF_W  = 32;
  localparam int ZOOM_W = 31;
  localparam int BOFF_W = 26;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;

  // Fixed-point format of the complex plane
  localparam int FRAC   = 28;
  localparam int Z_W    = FRAC + 6;   // iterate x, y (signed)
  localparam int SQ_W   = FRAC + 3;   // saturated squares, up to 4.0
  localparam int P_W    = FRAC + 3;   // |2xy| while still inside the radius

  localparam int ITER_LIMIT_MAX = 1024;
  localparam int ROM_DEPTH      = ITER_LIMIT_MAX + 1;

  // Mapping divider: |zoom*(2p-size)| < 2^44, divisor 2*size
  localparam int NUM_W   = 44;
  localparam int DEN_W   = SIZE_W + 1;
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int PROD_W  = ZOOM_W + 1 + PIX_W + 3;
  localparam int CSUM_W  = NUM_W + 2;

  // APB register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_ZOOM       = 3'd2;
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_MAX_ITER   = 3'd5;

  localparam logic [ZOOM_W-1:0] ZOOM_RST  = ZOOM_W'(1 << 30);
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(1024);
  localparam logic [ITER_W-1:0] ITER_RST  = ITER_W'(256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_ITER,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic [ZOOM_W-1:0]       zoom;
    logic [SIZE_W-1:0]       image_width;
    logic [SIZE_W-1:0]       image_height;
    logic [ITER_W-1:0]       max_iterations;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture pixel, clear iterate
    logic div_start;  // start mapping divide for the selected axis
    logic axis_y;     // 0: real axis, 1: imaginary axis
    logic c_wr;       // store mapped coordinate
    logic iter_en;    // run one z-update
    logic out_ld;     // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic iter_stop;
  } dp_status_t;

  // Colour table, built at elaboration
  localparam longint S_ONE     = 64'd1 << 28;
  localparam longint ANG_STEP  = 64'd26843546;
  localparam longint PH_RED    = 64'd0;
  localparam longint PH_GREEN  = 64'd562103845;
  localparam longint PH_BLUE   = 64'd1124207690;
  localparam longint PI_Q      = 64'd843314857;
  localparam longint HALF_PI_Q = 64'd421657428;

  typedef logic [RGB_W-1:0] color_tbl_t [ROM_DEPTH];

  function automatic logic [CH_W-1:0] colour_byte(longint n, longint ph);
    longint r;
    longint m;
    longint m2;
    longint t;
    longint s;
    longint v;
    longint c;
    logic   neg;
    r = (n * ANG_STEP + ph) % (2 * PI_Q);
    if (r >= PI_Q) r = r - 2 * PI_Q;
    if (r > HALF_PI_Q) r = PI_Q - r;
    else if (r < -HALF_PI_Q) r = -PI_Q - r;
    neg = (r < 0);
    m   = neg ? -r : r;
    m2  = (m * m) / S_ONE;
    // Horner form of the odd sine series up to x^13
    t = S_ONE;
    t = S_ONE - (m2 * t) / (156 * S_ONE);
    t = S_ONE - (m2 * t) / (110 * S_ONE);
    t = S_ONE - (m2 * t) / (72 * S_ONE);
    t = S_ONE - (m2 * t) / (42 * S_ONE);
    t = S_ONE - (m2 * t) / (20 * S_ONE);
    t = S_ONE - (m2 * t) / (6 * S_ONE);
    s = (m * t) / S_ONE;
    if (s > S_ONE) s = S_ONE;
    v = neg ? S_ONE - s : S_ONE + s;
    c = (255 * v) / (2 * S_ONE);
    if (c > 255) c = 255;
    return c[CH_W-1:0];
  endfunction

  function automatic color_tbl_t build_color_tbl();
    color_tbl_t tbl;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      tbl[i] = {colour_byte(longint'(i), PH_RED), colour_byte(longint'(i), PH_GREEN),
                colour_byte(longint'(i), PH_BLUE)};
    end
    return tbl;
  endfunction

endpackage

// ----- design/mbr_if.sv -----
interface mbr_pixel_if;
  import mbr_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbr_result_if;
  import mbr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iteration_count;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;
  logic [BOFF_W-1:0] byte_offset;

  modport source (output valid, output iteration_count, output red, output green,
                  output blue, output byte_offset, input ready);
  modport sink   (input valid, input iteration_count, input red, input green,
                  input blue, input byte_offset, output ready);
endinterface

// ----- design/mbr_regs.sv -----
module mbr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbr_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbr_pkg::DATA_W-1:0]  pwdata,
  output logic [mbr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mbr_pkg::cfg_t               cfg_o
);
  import mbr_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OFFSET_X:   cfg_d.offset_x       = pwdata;
        REG_OFFSET_Y:   cfg_d.offset_y       = pwdata;
        REG_ZOOM:       cfg_d.zoom           = pwdata[ZOOM_W-1:0];
        REG_IMG_WIDTH:  cfg_d.image_width    = pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT: cfg_d.image_height   = pwdata[SIZE_W-1:0];
        REG_MAX_ITER:   cfg_d.max_iterations = pwdata[ITER_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x       <= '0;
      cfg_q.offset_y       <= '0;
      cfg_q.zoom           <= ZOOM_RST;
      cfg_q.image_width    <= SIZE_RST;
      cfg_q.image_height   <= SIZE_RST;
      cfg_q.max_iterations <= ITER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_OFFSET_X:   prdata = cfg_q.offset_x;
      REG_OFFSET_Y:   prdata = cfg_q.offset_y;
      REG_ZOOM:       prdata = DATA_W'(cfg_q.zoom);
      REG_IMG_WIDTH:  prdata = DATA_W'(cfg_q.image_width);
      REG_IMG_HEIGHT: prdata = DATA_W'(cfg_q.image_height);
      REG_MAX_ITER:   prdata = DATA_W'(cfg_q.max_iterations);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- design/mbr_div.sv -----
module mbr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mbr_pkg::NUM_W-1:0]  num_i,
  input  logic [mbr_pkg::DEN_W-1:0]  den_i,
  output logic [mbr_pkg::NUM_W-1:0]  quo_o,
  output logic                       done_o
);
  import mbr_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  trial;
  logic              q_bit;

  // One restoring step: shift in the next dividend bit, try subtract
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign q_bit  = !trial[DEN_W+1];
  assign rem_d  = q_bit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  assign quo_o  = quo_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], q_bit};
    end
  end

endmodule

// ----- design/mbr_color_rom.sv -----
module mbr_color_rom (
  input  logic                          clk_i,
  input  logic [mbr_pkg::ITER_W-1:0]    addr_i,
  output logic [mbr_pkg::RGB_W-1:0]     data_o
);
  import mbr_pkg::*;

  localparam color_tbl_t ColorTbl = build_color_tbl();

  logic [RGB_W-1:0] data_q;

  // Registered read
  always_ff @(posedge clk_i) begin
    data_q <= ColorTbl[addr_i];
  end

  assign data_o = data_q;

endmodule

// ----- design/mbr_dp.sv -----
module mbr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbr_pkg::cfg_t              cfg_i,
  input  mbr_pkg::dp_cmd_t           cmd_i,
  output mbr_pkg::dp_status_t        status_o,
  input  logic [mbr_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [mbr_pkg::PIX_W-1:0]  pixel_y_i,
  output logic [mbr_pkg::ITER_W-1:0] iteration_count_o,
  output logic [mbr_pkg::CH_W-1:0]   red_o,
  output logic [mbr_pkg::CH_W-1:0]   green_o,
  output logic [mbr_pkg::CH_W-1:0]   blue_o,
  output logic [mbr_pkg::BOFF_W-1:0] byte_offset_o
);
  import mbr_pkg::*;

  logic [PIX_W-1:0]         px_q;
  logic [PIX_W-1:0]         py_q;
  logic [BOFF_W-1:0]        boff_q;
  logic                     sign_q;
  logic signed [OFF_W-1:0]  cx_q;
  logic signed [OFF_W-1:0]  cy_q;
  logic signed [Z_W-1:0]    zx_q;
  logic signed [Z_W-1:0]    zy_q;
  logic [ITER_W-1:0]        n_q;
  logic [ITER_W-1:0]        cnt_out_q;
  logic [RGB_W-1:0]         rgb_q;
  logic [BOFF_W-1:0]        boff_out_q;

  // Byte address of the pixel
  logic [SIZE_W+PIX_W-1:0]  wy;
  logic [BOFF_W-1:0]        lin;

  assign wy  = cfg_i.image_width * pixel_y_i;
  assign lin = BOFF_W'(wy) + BOFF_W'(pixel_x_i);

  // Map pixel to zoom*(2p - size), divisor 2*size
  logic [SIZE_W-1:0]         s_raw;
  logic [SIZE_W-1:0]         s_eff;
  logic [PIX_W-1:0]          p_sel;
  logic signed [PIX_W+2:0]   diff;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         prod_mag;
  logic [DEN_W-1:0]          den;
  logic [NUM_W-1:0]          quo;
  logic                      div_done;

  assign s_raw    = cmd_i.axis_y ? cfg_i.image_height : cfg_i.image_width;
  assign s_eff    = (s_raw == '0) ? SIZE_W'(1) : s_raw;
  assign p_sel    = cmd_i.axis_y ? py_q : px_q;
  assign diff     = $signed({2'b00, p_sel, 1'b0}) - $signed({2'b00, s_eff});
  assign prod     = $signed({1'b0, cfg_i.zoom}) * diff;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign den      = {s_eff, 1'b0};

  mbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_mag[NUM_W-1:0]),
    .den_i   (den),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // Offset plus signed quotient, saturated to 32 bits
  logic signed [OFF_W-1:0]  off_sel;
  logic signed [CSUM_W-1:0] q_signed;
  logic signed [CSUM_W-1:0] csum;
  logic signed [OFF_W-1:0]  c_sat;

  assign off_sel  = cmd_i.axis_y ? cfg_i.offset_y : cfg_i.offset_x;
  assign q_signed = sign_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign csum     = q_signed + CSUM_W'(off_sel);

  always_comb begin
    if (csum[CSUM_W-1:OFF_W-1] == {(CSUM_W-OFF_W+1){csum[OFF_W-1]}}) begin
      c_sat = csum[OFF_W-1:0];
    end else if (csum[CSUM_W-1]) begin
      c_sat = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      c_sat = {1'b0, {(OFF_W-1){1'b1}}};
    end
  end

  // One z-update: squares and cross product of the current z
  logic [Z_W-1:0]          mx;
  logic [Z_W-1:0]          my;
  logic [2*FRAC+1:0]       xsq;
  logic [2*FRAC+1:0]       ysq;
  logic [2*FRAC+1:0]       xy;
  logic [SQ_W-1:0]         xx;
  logic [SQ_W-1:0]         yy;
  logic [P_W-1:0]          p2xy;
  logic signed [Z_W-1:0]   nx;
  logic signed [Z_W-1:0]   ny;
  logic                    escaped;
  logic [ITER_W-1:0]       lim;
  logic                    stop;

  assign mx   = zx_q[Z_W-1] ? Z_W'(-zx_q) : Z_W'(zx_q);
  assign my   = zy_q[Z_W-1] ? Z_W'(-zy_q) : Z_W'(zy_q);
  assign xsq  = mx[FRAC:0] * mx[FRAC:0];
  assign ysq  = my[FRAC:0] * my[FRAC:0];
  assign xy   = mx[FRAC:0] * my[FRAC:0];

  // Saturate a square to 4.0 once the operand reaches 2.0
  assign xx   = (mx[Z_W-1:FRAC+1] != '0) ? SQ_W'(1) << (FRAC + 2)
                                         : {1'b0, xsq[2*FRAC+1:FRAC]};
  assign yy   = (my[Z_W-1:FRAC+1] != '0) ? SQ_W'(1) << (FRAC + 2)
                                         : {1'b0, ysq[2*FRAC+1:FRAC]};
  assign p2xy = xy[2*FRAC+1:FRAC-1];

  assign ny = ((zx_q[Z_W-1] ^ zy_q[Z_W-1]) ? -$signed(Z_W'(p2xy)) : $signed(Z_W'(p2xy)))
              + Z_W'(cy_q);
  assign nx = $signed(Z_W'(xx)) - $signed(Z_W'(yy)) + Z_W'(cx_q);

  assign escaped = ({1'b0, xx} + {1'b0, yy}) >= ((SQ_W+1)'(1) << (FRAC + 2));
  assign lim     = (cfg_i.max_iterations > ITER_W'(ITER_LIMIT_MAX)) ?
                   ITER_W'(ITER_LIMIT_MAX) : cfg_i.max_iterations;
  assign stop    = (n_q >= lim) || escaped;

  assign status_o.div_done  = div_done;
  assign status_o.iter_stop = stop;

  // Colour lookup for the final count
  logic [RGB_W-1:0] rom_data;

  mbr_color_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (n_q),
    .data_o (rom_data)
  );

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      boff_q <= {lin[BOFF_W-3:0], 2'b00};
      zx_q   <= '0;
      zy_q   <= '0;
      n_q    <= '0;
    end else if (cmd_i.iter_en && !stop) begin
      zx_q <= nx;
      zy_q <= ny;
      n_q  <= n_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      sign_q <= prod[PROD_W-1];
    end
    if (cmd_i.c_wr) begin
      if (cmd_i.axis_y) begin
        cy_q <= c_sat;
      end else begin
        cx_q <= c_sat;
      end
    end
    if (cmd_i.out_ld) begin
      cnt_out_q  <= n_q;
      rgb_q      <= rom_data;
      boff_out_q <= boff_q;
    end
  end

  assign iteration_count_o = cnt_out_q;
  assign red_o             = rgb_q[RGB_W-1:2*CH_W];
  assign green_o           = rgb_q[2*CH_W-1:CH_W];
  assign blue_o            = rgb_q[CH_W-1:0];
  assign byte_offset_o     = boff_out_q;

endmodule

// ----- design/mbr_ctrl.sv -----
module mbr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mbr_pkg::dp_status_t  st_i,
  output mbr_pkg::dp_cmd_t     cmd_o
);
  import mbr_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START_X;
        end
      end
      ST_START_X: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (st_i.div_done) begin
          cmd_o.c_wr = 1'b1;
          state_d    = ST_START_Y;
        end
      end
      ST_START_Y: begin
        cmd_o.axis_y    = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        cmd_o.axis_y = 1'b1;
        if (st_i.div_done) begin
          cmd_o.c_wr = 1'b1;
          state_d    = ST_ITER;
        end
      end
      ST_ITER: begin
        cmd_o.iter_en = 1'b1;
        if (st_i.iter_stop) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_START_X))
    else $error("accepted request did not start mapping");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before taken");

  a_stop_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && st_i.iter_stop) |=> (state_q == ST_LOOKUP))
    else $error("iteration stop not followed by lookup");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

// ----- design/mandelbrot_escape_time_pixel.sv -----
// Channel   Dir  Handshake        Payload
// pix_i     in   valid / ready    pixel_x[11:0], pixel_y[11:0]
// res_o     out  valid / ready    iteration_count[10:0], red, green, blue, byte_offset[25:0]
// apb       in   psel / penable   paddr[4:0], pwdata[31:0], prdata[31:0], pready
//
// One pixel at a time: accept, two restoring divides for the mapping on the shared
// mapping divider, then one z-update per cycle until the count stops, then one colour lookup.
// Reset (rst_ni low, asynchronous) loads the register defaults and empties the block.
// A finished result waits in the output register; the next pixel is accepted meanwhile.
module mandelbrot_escape_time_pixel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mbr_pixel_if.sink                   pix_i,
  mbr_result_if.source                res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbr_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbr_pkg::DATA_W-1:0]  pwdata,
  output logic [mbr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import mbr_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  mbr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .st_i        (status),
    .cmd_o       (cmd)
  );

  mbr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .pixel_x_i         (pix_i.pixel_x),
    .pixel_y_i         (pix_i.pixel_y),
    .iteration_count_o (res_o.iteration_count),
    .red_o             (res_o.red),
    .green_o           (res_o.green),
    .blue_o            (res_o.blue),
    .byte_offset_o     (res_o.byte_offset)
  );

endmodule

// ----- dv/mandelbrot_escape_time_pixel_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
  import mbr_pkg::*;

  localparam int          RUN_LIMIT   = 4_000_000;
  localparam int          DRAIN_LIMIT = 200_000;
  localparam longint      FOUR_Q      = 64'd4 << FRAC;
  localparam longint      TWO_Q       = 64'd2 << FRAC;
  localparam longint      SINE_ONE    = 64'd1 << 28;
  localparam longint      HUE_STEP    = 64'd26843546;
  localparam longint      HUE_GREEN   = 64'd562103845;
  localparam longint      HUE_BLUE    = 64'd1124207690;
  localparam longint      HUE_PI      = 64'd843314857;
  localparam longint      HUE_HALF_PI = 64'd421657428;

  typedef struct {
    logic [ITER_W-1:0] iteration_count;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [BOFF_W-1:0] byte_offset;
  } pixel_result_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mbr_pixel_if  pix ();
  mbr_result_if res ();

  mandelbrot_escape_time_pixel DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the view registers
  longint          view_off_x;
  longint          view_off_y;
  longint unsigned view_zoom;
  longint unsigned view_width;
  longint unsigned view_height;
  longint unsigned view_max_iter;

  pixel_result_t pending_pixels[$];
  int            fail_count;
  int            cycle_count;
  int            src_idle_pct;
  int            snk_idle_pct;
  int            hold_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Map one pixel axis onto the complex plane, saturated to 32 bits
  function automatic longint map_axis(longint unsigned p, longint unsigned size, longint off);
    longint s;
    longint num;
    longint c;
    s   = (size == 0) ? 1 : longint'(size);
    num = longint'(view_zoom) * (2 * longint'(p) - s);
    c   = off + num / (2 * s);
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c;
  endfunction

  function automatic longint unsigned abs_q(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned square_q(longint v);
    longint unsigned m;
    logic [127:0]    prod;
    m = abs_q(v);
    if (m >= TWO_Q) return FOUR_Q;
    prod = 128'(m) * 128'(m);
    return prod[FRAC +: 64];
  endfunction

  // Palette byte for one count and phase
  function automatic logic [CH_W-1:0] hue_byte(longint unsigned n, longint unsigned ph);
    longint          r;
    longint unsigned m;
    longint unsigned m2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    longint unsigned c;
    longint unsigned dens[6];
    bit              neg;
    dens = '{156, 110, 72, 42, 20, 6};
    r = longint'((n * HUE_STEP + ph) % (2 * HUE_PI));
    if (r >= HUE_PI) r = r - 2 * HUE_PI;
    if (r > HUE_HALF_PI) r = HUE_PI - r;
    else if (r < -HUE_HALF_PI) r = -HUE_PI - r;
    neg = (r < 0);
    m   = abs_q(r);
    m2  = (m * m) >> 28;
    t   = SINE_ONE;
    for (int i = 0; i < 6; i++) begin
      t = SINE_ONE - (m2 * t) / (dens[i] << 28);
    end
    s = (m * t) >> 28;
    if (s > SINE_ONE) s = SINE_ONE;
    v = neg ? SINE_ONE - s : SINE_ONE + s;
    c = (255 * v) / (2 * SINE_ONE);
    if (c > 255) c = 255;
    return c[CH_W-1:0];
  endfunction

  // Escape-time result for one pixel under the current view
  function automatic pixel_result_t escape_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    pixel_result_t   r;
    longint          cx;
    longint          cy;
    longint          x;
    longint          y;
    longint          ny;
    longint unsigned xx;
    longint unsigned yy;
    longint unsigned n;
    longint unsigned lim;
    longint unsigned p;
    logic [127:0]    prod;
    cx  = map_axis(px, view_width, view_off_x);
    cy  = map_axis(py, view_height, view_off_y);
    lim = (view_max_iter > ITER_LIMIT_MAX) ? ITER_LIMIT_MAX : view_max_iter;
    x = 0; y = 0; xx = 0; yy = 0; n = 0;
    while (n < lim && xx + yy < FOUR_Q) begin
      prod = 128'(abs_q(x)) * 128'(abs_q(y));
      p    = prod[FRAC-1 +: 64];
      ny   = (((x < 0) != (y < 0)) ? -longint'(p) : longint'(p)) + cy;
      x    = longint'(xx) - longint'(yy) + cx;
      y    = ny;
      xx   = square_q(x);
      yy   = square_q(y);
      n++;
    end
    r.iteration_count = n[ITER_W-1:0];
    r.red             = hue_byte(n, 0);
    r.green           = hue_byte(n, HUE_GREEN);
    r.blue            = hue_byte(n, HUE_BLUE);
    r.byte_offset     = BOFF_W'(4 * (view_width * py + px));
    return r;
  endfunction

  // Receive results, compare in order, drive ready
  always @(posedge clk_i) begin
    pixel_result_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result, count %0d", res.iteration_count);
        fail_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (res.iteration_count !== e.iteration_count) begin
          $error("iteration_count exp %0d got %0d", e.iteration_count, res.iteration_count);
          fail_count++;
        end
        if (res.red !== e.red) begin
          $error("red exp %0d got %0d", e.red, res.red);
          fail_count++;
        end
        if (res.green !== e.green) begin
          $error("green exp %0d got %0d", e.green, res.green);
          fail_count++;
        end
        if (res.blue !== e.blue) begin
          $error("blue exp %0d got %0d", e.blue, res.blue);
          fail_count++;
        end
        if (res.byte_offset !== e.byte_offset) begin
          $error("byte_offset exp %0d got %0d", e.byte_offset, res.byte_offset);
          fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res.ready   <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Register write: setup then access phase
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_OFFSET_X:   view_off_x    = longint'($signed(value));
      REG_OFFSET_Y:   view_off_y    = longint'($signed(value));
      REG_ZOOM:       view_zoom     = value[30:0];
      REG_IMG_WIDTH:  view_width    = value[12:0];
      REG_IMG_HEIGHT: view_height   = value[12:0];
      REG_MAX_ITER:   view_max_iter = value[10:0];
      default: ;
    endcase
  endtask

  // Drop valid and hold until every request is answered
  task automatic drain();
    int waited;
    waited = 0;
    @(posedge clk_i);
    pix.valid <= 1'b0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      $display("status: fail");
      $finish;
    end
  endtask

  // Offer one pixel request; valid stays high for a back-to-back follower
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pending_pixels.push_back(escape_pixel(px, py));
  endtask

  task automatic set_view(logic [31:0] ox, logic [31:0] oy, logic [31:0] zm,
                          logic [31:0] w, logic [31:0] h, logic [31:0] it);
    drain();
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_ZOOM, zm);
    write_reg(REG_IMG_WIDTH, w);
    write_reg(REG_IMG_HEIGHT, h);
    write_reg(REG_MAX_ITER, it);
  endtask

  // Random view, mostly near the interesting part of the set
  task automatic random_view();
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] zm;
    logic [31:0] it;
    if ($urandom_range(9) == 0) begin
      ox = $urandom;
      oy = $urandom;
      zm = $urandom;
    end else begin
      ox = 32'($urandom_range(0, 32'h3FFF_FFFF)) - 32'h2000_0000;
      oy = 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
      zm = 32'($urandom_range(1, 32'h3FFF_FFFF));
    end
    case ($urandom_range(19))
      0:       it = $urandom_range(1025, 2047);
      1, 2, 3: it = $urandom_range(129, 400);
      default: it = $urandom_range(1, 128);
    endcase
    set_view(ox, oy, zm, $urandom_range(1, 4096), $urandom_range(1, 4096), it);
  endtask

  task automatic test_directed();
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(512, 512);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hFFF, 0);
    // Zero image size, pixel beyond the image
    set_view(32'hF400_0000, 0, 32'h3000_0000, 0, 0, 64);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hABC);
    set_view(0, 0, 32'h4000_0000, 100, 50, 32);
    send_pixel(4000, 3000);
    send_pixel(99, 49);
    // Limit zero, and a limit above the ceiling on a point that never escapes
    set_view(0, 0, 32'h4000_0000, 1024, 1024, 0);
    send_pixel(512, 512);
    set_view(0, 0, 32'h4000_0000, 1024, 1024, 32'hFFFF_FFFF);
    send_pixel(512, 512);
    // Saturated mapping at the extremes of offset and zoom
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 8);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 0, 4096, 4096, 1);
    send_pixel(100, 200);
    // Address wrap with the widest row
    set_view(32'hF800_0000, 32'h0200_0000, 32'h0800_0000, 8191, 8191, 1024);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'hAAA, 12'h555);
  endtask

  task automatic test_random(int n_items);
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    for (int i = 0; i < n_items; i++) begin
      if (i % 35 == 0) random_view();
      if ($urandom_range(9) == 0) begin
        px = PIX_W'($urandom);
        py = PIX_W'($urandom);
      end else begin
        px = PIX_W'($urandom_range(0, (view_width  == 0) ? 0 : view_width  - 1));
        py = PIX_W'($urandom_range(0, (view_height == 0) ? 0 : view_height - 1));
      end
      send_pixel(px, py);
    end
  endtask

  // Long receiver stall while requests keep coming, then a full pause
  task automatic test_backpressure();
    set_view(32'hF800_0000, 0, 32'h3000_0000, 64, 64, 16);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_cycles  = 2000;
    for (int i = 0; i < 8; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 63)), PIX_W'($urandom_range(0, 63)));
    end
    drain();
    for (int i = 0; i < 4; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 63)), PIX_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    int waited;
    fail_count   = 0;
    cycle_count  = 0;
    src_idle_pct = 13;
    snk_idle_pct = 55;
    hold_cycles  = 0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.pixel_x  = '0;
    pix.pixel_y  = '0;
    res.ready    = 1'b0;
    view_off_x    = 0;
    view_off_y    = 0;
    view_zoom     = 64'd1 << 30;
    view_width    = 1024;
    view_height   = 1024;
    view_max_iter = 256;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(140);
    src_idle_pct = 55;
    snk_idle_pct = 13;
    test_random(140);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(140);
    test_backpressure();

    // Wait out the tail
    @(posedge clk_i);
    pix.valid <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mbr_pkg.sv
design/mbr_if.sv
design/mbr_regs.sv
design/mbr_div.sv
design/mbr_color_rom.sv
design/mbr_dp.sv
design/mbr_ctrl.sv
design/mandelbrot_escape_time_pixel.sv
dv/mandelbrot_escape_time_pixel_tb.sv
